// File: hdl/ecd_pkg.sv
// shared constants, operation codes and controller/datapath interface types
package ecd_pkg;

   localparam int NUM_PORTS_DEF  = 1024;
   localparam int WORD_BITS_DEF  = 64;
   localparam int COUNT_BITS_DEF = 32;

   localparam int FUNC_W      = 3;
   localparam int PORT_W      = 10;
   localparam int COUNT_OUT_W = 32;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 48;

   // reciprocal precision for splitting a port number into group and bit
   localparam int DIV_SHIFT = 16;

   localparam logic [FUNC_W-1:0] FUNC_RAISE    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MASK     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNMASK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 3'd4;

   typedef struct packed {
      logic clr_en;
      logic take_req;
      logic decode;
      logic exec_op;
      logic snap;
      logic pick_grp;
      logic drop_grp;
      logic take_port;
      logic cnt_rd;
      logic cnt_wr;
      logic load_out;
   } ecd_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_dispatch;
      logic work_empty;
      logic act_zero;
   } ecd_sts_type;

endpackage

// File: hdl/event_channel_dispatcher.sv
// Event-channel dispatcher with two-level pending bitmap.
// Raise, mask, unmask, clear and unused codes pass through decode, execute and done
// before the next accept; the done state loads the result once no held result waits.
// Dispatch searches one group per step and drops emptied groups; it takes one fresh
// snapshot if the work selector is empty, and on a hit does the count read-modify-write.
// After reset the count memory is zeroed one entry per cycle, all NUM_PORTS entries,
// before the first request transfer; configuration writes are taken at any time.
module event_channel_dispatcher #(
   parameter int NUM_PORTS  = ecd_pkg::NUM_PORTS_DEF,
   parameter int WORD_BITS  = ecd_pkg::WORD_BITS_DEF,
   parameter int COUNT_BITS = ecd_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // func [2:0], port [12:3]
   input  logic [ecd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // found [0], port_out [10:1], count_out [42:11], upcall_flag [43],
   // callback_request [44]
   output logic [ecd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // upcall_masked
   input  logic                            csr_data,
   input  logic                            csr_valid,
   output logic                            csr_ready
);
   import ecd_pkg::*;

   ecd_cmd_type cmd;
   ecd_sts_type sts;

   assign csr_ready = 1'b1;

   ecd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ecd_datapath #(
      .NUM_PORTS  (NUM_PORTS),
      .WORD_BITS  (WORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: hdl/ecd_ram.sv
// generic simple dual-port ram with registered read
module ecd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ecd_datapath.sv
// bitmaps, selectors, port decode, count memory and result register
module ecd_datapath #(
   parameter int NUM_PORTS  = 1024,
   parameter int WORD_BITS  = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ecd_pkg::ecd_cmd_type            cmd,
   output ecd_pkg::ecd_sts_type            sts,
   input  logic [ecd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_data,
   output logic [ecd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ecd_pkg::*;

   localparam int NUM_GROUPS = NUM_PORTS / WORD_BITS;
   localparam int PORTS_USED = NUM_GROUPS * WORD_BITS;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int ADDR_W     = $clog2(NUM_PORTS);
   localparam int RECIP      = (1 << DIV_SHIFT) / WORD_BITS;
   localparam int PROD_W     = PORT_W + DIV_SHIFT;

   logic                  upcall_masked_ff, upcall_masked_in;
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [PORT_W-1:0]     port_ff, port_in;
   logic [PORT_W-1:0]     gest_ff, gest_in;
   logic [GRP_W-1:0]      grp_ff, grp_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic                  in_range_ff, in_range_in;
   logic [WORD_BITS-1:0]  pend_ff [NUM_GROUPS];
   logic [WORD_BITS-1:0]  pend_in [NUM_GROUPS];
   logic [WORD_BITS-1:0]  mask_ff [NUM_GROUPS];
   logic [WORD_BITS-1:0]  mask_in [NUM_GROUPS];
   logic [NUM_GROUPS-1:0] gsel_ff, gsel_in;
   logic [NUM_GROUPS-1:0] work_ff, work_in;
   logic                  upcall_ff, upcall_in;
   logic [ADDR_W-1:0]     paddr_ff, paddr_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  res_found_ff, res_found_in;
   logic                  res_cb_ff, res_cb_in;
   logic [COUNT_BITS-1:0] res_count_ff, res_count_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PROD_W-1:0]     prod;
   logic [PORT_W-1:0]     rem;
   logic                  rem_hi;
   logic [PORT_W-1:0]     grp_dec;
   logic [PORT_W-1:0]     bit_dec;
   logic [WORD_BITS-1:0]  act;
   logic [WORD_BITS-1:0]  sel_bit;
   logic [BIT_W-1:0]      low_bit;
   logic [GRP_W-1:0]      low_grp;
   logic [COUNT_BITS-1:0] cnt_rd_data;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic [PORT_W-1:0]     port_out;
   logic [COUNT_OUT_W-1:0] count_out;

   // group estimate by reciprocal, low by at most one
   assign prod    = PROD_W'(req_tdata[FUNC_W +: PORT_W]) * PROD_W'(RECIP);
   assign rem     = port_ff - PORT_W'(gest_ff * PORT_W'(WORD_BITS));
   assign rem_hi  = rem >= PORT_W'(WORD_BITS);
   assign grp_dec = rem_hi ? gest_ff + PORT_W'(1) : gest_ff;
   assign bit_dec = rem_hi ? rem - PORT_W'(WORD_BITS) : rem;

   assign act     = pend_ff[grp_ff] & ~mask_ff[grp_ff];
   assign sel_bit = WORD_BITS'(1) << bit_ff;
   assign count_inc = cnt_rd_data + COUNT_BITS'(1);

   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (act[i]) begin
            low_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      low_grp = '0;
      for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
         if (work_ff[i]) begin
            low_grp = GRP_W'(i);
         end
      end
   end

   // request decode and operand registers
   always_comb begin
      func_in     = func_ff;
      port_in     = port_ff;
      gest_in     = gest_ff;
      grp_in      = grp_ff;
      bit_in      = bit_ff;
      in_range_in = in_range_ff;
      paddr_in    = paddr_ff;
      clr_addr_in = clr_addr_ff;
      upcall_masked_in = csr_valid ? csr_data : upcall_masked_ff;
      if (cmd.take_req) begin
         func_in = req_tdata[FUNC_W-1:0];
         port_in = req_tdata[FUNC_W +: PORT_W];
         gest_in = prod[DIV_SHIFT +: PORT_W];
      end
      if (cmd.decode) begin
         grp_in      = GRP_W'(grp_dec);
         bit_in      = BIT_W'(bit_dec);
         in_range_in = int'(port_ff) < PORTS_USED;
      end
      if (cmd.pick_grp) begin
         grp_in = low_grp;
      end
      if (cmd.take_port) begin
         paddr_in = ADDR_W'(int'(grp_ff) * WORD_BITS + int'(low_bit));
      end
      if (cmd.clr_en) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end
   end

   // bitmap and selector updates
   always_comb begin
      pend_in   = pend_ff;
      mask_in   = mask_ff;
      gsel_in   = gsel_ff;
      work_in   = work_ff;
      upcall_in = upcall_ff;
      res_cb_in = res_cb_ff;
      if (cmd.take_req) begin
         res_cb_in = 1'b0;
      end
      if (cmd.exec_op && in_range_ff) begin
         case (func_ff)
            FUNC_RAISE: begin
               if ((pend_ff[grp_ff] & sel_bit) == '0) begin
                  pend_in[grp_ff] = pend_ff[grp_ff] | sel_bit;
                  if ((mask_ff[grp_ff] & sel_bit) == '0 && !gsel_ff[grp_ff]) begin
                     gsel_in[grp_ff] = 1'b1;
                     upcall_in       = 1'b1;
                  end
               end
            end
            FUNC_MASK: begin
               mask_in[grp_ff] = mask_ff[grp_ff] | sel_bit;
            end
            FUNC_UNMASK: begin
               mask_in[grp_ff] = mask_ff[grp_ff] & ~sel_bit;
               if ((pend_ff[grp_ff] & sel_bit) != '0 && !gsel_ff[grp_ff]) begin
                  gsel_in[grp_ff] = 1'b1;
                  upcall_in       = 1'b1;
                  res_cb_in       = !upcall_masked_ff;
               end
            end
            FUNC_CLEAR: begin
               pend_in[grp_ff] = pend_ff[grp_ff] & ~sel_bit;
            end
            default: begin
            end
         endcase
      end
      if (cmd.snap) begin
         work_in   = gsel_ff;
         gsel_in   = '0;
         upcall_in = 1'b0;
      end
      if (cmd.drop_grp) begin
         work_in[grp_ff] = 1'b0;
      end
      if (cmd.take_port) begin
         pend_in[grp_ff] = pend_ff[grp_ff] & ~(WORD_BITS'(1) << low_bit);
      end
   end

   // result fields
   always_comb begin
      res_found_in = res_found_ff;
      res_count_in = res_count_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.take_req) begin
         res_found_in = 1'b0;
      end
      if (cmd.cnt_wr) begin
         res_found_in = 1'b1;
         res_count_in = count_inc;
      end
      if (cmd.load_out) begin
         rsp_data_in = {3'b000, res_cb_ff, upcall_ff, count_out, port_out, res_found_ff};
      end
   end

   assign port_out  = res_found_ff ? PORT_W'(paddr_ff) : '0;
   assign count_out = res_found_ff ? COUNT_OUT_W'(res_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         upcall_masked_ff <= 1'b0;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            pend_ff[g] <= '0;
            mask_ff[g] <= '1;
         end
         gsel_ff      <= '0;
         work_ff      <= '0;
         upcall_ff    <= 1'b0;
         clr_addr_ff  <= '0;
         res_found_ff <= 1'b0;
         res_cb_ff    <= 1'b0;
      end else begin
         upcall_masked_ff <= upcall_masked_in;
         pend_ff      <= pend_in;
         mask_ff      <= mask_in;
         gsel_ff      <= gsel_in;
         work_ff      <= work_in;
         upcall_ff    <= upcall_in;
         clr_addr_ff  <= clr_addr_in;
         res_found_ff <= res_found_in;
         res_cb_ff    <= res_cb_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      port_ff      <= port_in;
      gest_ff      <= gest_in;
      grp_ff       <= grp_in;
      bit_ff       <= bit_in;
      in_range_ff  <= in_range_in;
      paddr_ff     <= paddr_in;
      res_count_ff <= res_count_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // count store: zero fill after reset, then read-modify-write per dispatch that finds a port
   assign ram_wr_en   = cmd.clr_en | cmd.cnt_wr;
   assign ram_wr_addr = cmd.clr_en ? clr_addr_ff : paddr_ff;
   assign ram_wr_data = cmd.clr_en ? '0 : count_inc;

   ecd_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_PORTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.cnt_rd),
      .rd_addr (paddr_ff),
      .rd_data (cnt_rd_data)
   );

   assign sts.clr_last    = clr_addr_ff == ADDR_W'(NUM_PORTS - 1);
   assign sts.is_dispatch = func_ff == FUNC_DISPATCH;
   assign sts.work_empty  = work_ff == '0;
   assign sts.act_zero    = act == '0;

   assign rsp_tdata = rsp_data_ff;

   a_found_after_write: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_wr |=> res_found_ff)
      else $error("count write did not mark a found port");

   a_cb_only_unmask: assert property (@(posedge clock) disable iff (reset)
      res_cb_ff |-> func_ff == FUNC_UNMASK)
      else $error("callback request outside unmask");

   a_snap_clears_upcall: assert property (@(posedge clock) disable iff (reset)
      cmd.snap |=> !upcall_ff && gsel_ff == '0)
      else $error("snapshot left selector or upcall flag set");

endmodule

// File: hdl/ecd_controller.sv
// sequencing state machine: clear sweep, decode, operation, dispatch search
module ecd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ecd_pkg::ecd_sts_type sts,
   output ecd_pkg::ecd_cmd_type cmd
);
   import ecd_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_DECODE = 9'b000000100,
      ST_EXEC   = 9'b000001000,
      ST_PICK   = 9'b000010000,
      ST_TEST   = 9'b000100000,
      ST_CNT_RD = 9'b001000000,
      ST_CNT_WR = 9'b010000000,
      ST_DONE   = 9'b100000000
   } ecd_state_type;

   ecd_state_type state_ff, state_in;
   logic          retry_ff, retry_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      retry_in   = retry_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            retry_in   = 1'b0;
            state_in   = sts.is_dispatch ? ST_PICK : ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec_op = 1'b1;
            state_in    = ST_DONE;
         end
         ST_PICK: begin
            // empty work selector: one fresh snapshot, then give up
            if (sts.work_empty) begin
               if (!retry_ff) begin
                  cmd.snap = 1'b1;
                  retry_in = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.pick_grp = 1'b1;
               state_in     = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sts.act_zero) begin
               cmd.drop_grp = 1'b1;
               state_in     = ST_PICK;
            end else begin
               cmd.take_port = 1'b1;
               state_in      = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         retry_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         retry_ff     <= retry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_decode: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_DECODE)
      else $error("accepted transfer not followed by decode");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CNT_WR |-> $past(state_ff == ST_CNT_RD))
      else $error("count write without preceding read");

endmodule
